// File: rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character constants and the hex digit helper for the URL
// percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam int unsigned RSP_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] HEX_TEN    = 8'd10;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_PCT  = 3'b010,
      PHASE_HELD = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_marker;
   } rsp_item_type;

   // Results produced by one decoded item: zero, one or two of them.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   // Value of a hex digit; bad digits simply give a wrapped value.
   function automatic logic [7:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      v = c;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         return c - CH_ZERO;
      end
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         v = c + CASE_SHIFT;
      end
      return v - CH_LOWER_A + HEX_TEN;
   endfunction

endpackage

// File: rtl/upd_decoder.sv
// ----------------------------------------------------------------------------
// upd_decoder
// Input register, escape state and the per-item decode that produces up to
// two result items for the result queue.
// ----------------------------------------------------------------------------
module upd_decoder
   import upd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_flag,
   input  logic       room,
   output push_type   push
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_end_ff, in_end_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       advance;
   logic       take;
   push_type   res;

   assign advance   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
         in_end_in   = req_end_flag;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_item_type term;
      rsp_item_type data;
      logic [7:0]   hi_val;
      logic [7:0]   lo_val;
      term.out_byte   = 8'h00;
      term.end_marker = 1'b1;
      data.out_byte   = in_byte_ff;
      data.end_marker = 1'b0;
      hi_val          = digit_value(held_ff);
      lo_val          = digit_value(in_byte_ff);
      res.count = 2'd0;
      res.item0 = term;
      res.item1 = term;
      phase_in  = phase_ff;
      held_in   = held_ff;
      if (in_end_ff) begin
         // A held byte after a dropped percent sign is decoded as if no escape had started.
         if (phase_ff == PHASE_HELD && held_ff != CH_PERCENT) begin
            res.count         = 2'd2;
            res.item0.out_byte   = (held_ff == CH_PLUS) ? CH_SPACE : held_ff;
            res.item0.end_marker = 1'b0;
         end else begin
            res.count = 2'd1;
         end
         phase_in = PHASE_IDLE;
         held_in  = 8'h00;
      end else begin
         case (phase_ff)
            PHASE_PCT: begin
               held_in  = in_byte_ff;
               phase_in = PHASE_HELD;
            end
            PHASE_HELD: begin
               // The low digit keeps all its bits, so a bad digit can spill
               // into the high nibble.
               res.count = 2'd1;
               res.item0.out_byte   = {hi_val[3:0], 4'h0} | lo_val;
               res.item0.end_marker = 1'b0;
               phase_in = PHASE_IDLE;
            end
            default: begin
               phase_in = PHASE_IDLE;
               if (in_byte_ff == CH_PERCENT) begin
                  phase_in = PHASE_PCT;
               end else begin
                  res.count = 2'd1;
                  res.item0 = data;
                  if (in_byte_ff == CH_PLUS) begin
                     res.item0.out_byte = CH_SPACE;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      push = res;
      if (!advance) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PHASE_IDLE;
         held_ff     <= 8'h00;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            held_ff  <= held_in;
         end
      end
   end

endmodule

// File: rtl/upd_rsp_fifo.sv
// ----------------------------------------------------------------------------
// upd_rsp_fifo
// Small result queue that takes up to two items per cycle and gives one while the receiver is ready.
// ----------------------------------------------------------------------------
module upd_rsp_fifo
   import upd_pkg::*;
#(
   parameter int unsigned DEPTH = RSP_DEPTH_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_end_marker
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   rsp_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_next;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == LAST) ? '0 : p + 1'b1;
   endfunction

   // Two free entries are needed since one item can yield two results.
   assign room           = count_ff <= CNT_W'(DEPTH - 2);
   assign rsp_valid      = count_ff != '0;
   assign pop            = rsp_valid && rsp_ready;
   assign rsp_out_byte   = mem_ff[rd_ptr_ff].out_byte;
   assign rsp_end_marker = mem_ff[rd_ptr_ff].end_marker;
   assign wr_ptr_next    = wrap_inc(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = wrap_inc(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/url_percent_decoder_top.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_top
// Path: an accepted item is registered in the input register, then decoded and written into the result queue.
// Throughput: one input item per cycle while the result queue has room; an end item
// that flushes a held byte yields two result items.
// Reset: synchronous, active high; clears the escape state and empties queue.
// ----------------------------------------------------------------------------
module url_percent_decoder_top
   import upd_pkg::*;
#(
   // Depth of the result queue; at least four keeps one item per cycle while the receiver is ready.
   parameter int unsigned RSP_DEPTH = RSP_DEPTH_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_flag,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_end_marker
);

   // The decoder registers each accepted item, then, once the queue has room,
   // decodes it against the escape state and pushes its results into the
   // queue. The queue parts the two sides, so new items keep flowing while a
   // result waits to be taken. The decoder advances only while the queue has
   // two free entries, which covers the worst case of one item.

   push_type push;
   logic     room;

   upd_decoder u_decoder (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_end_flag (req_end_flag),
      .room         (room),
      .push         (push)
   );

   upd_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .room           (room),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_end_marker (rsp_end_marker)
   );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the URL percent decoder. A queue of encoded items,
// directed cases first and then random strings, feeds a valid/ready driver.
// Each accepted item runs through a local decoder model that queues the
// decoded result items it implies. A monitor checks every result item against
// the oldest queued one. Both sides idle at random in two of the three patterns, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
   import upd_pkg::*;

   // One encoded input item as the driver offers it.
   typedef struct packed {
      logic [7:0] code;
      logic       is_end;
   } enc_item_type;

   // Idle patterns: sender and receiver idle percentages per phase.
   typedef enum int {
      MODE_SEND27_RECV57,
      MODE_SEND57_RECV27,
      MODE_STEADY
   } idle_mode_type;

   localparam int CYCLE_LIMIT    = 100000;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_ITEMS    = 200;
   localparam int DRAIN_CYCLES   = 10;
   localparam int MAX_REPORTED   = 10;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte    = 8'h00;
   logic       req_end_flag   = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_end_marker;

   enc_item_type  pending_items[$];
   rsp_item_type  decoded_queue[$];
   idle_mode_type idle_mode = MODE_SEND27_RECV57;

   // State of the local decoder model.
   phase_type  model_phase = PHASE_IDLE;
   logic [7:0] model_held  = 8'h00;

   int cycle_count   = 0;
   int error_count   = 0;
   int items_sent    = 0;
   int ends_sent     = 0;
   int results_seen  = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   url_percent_decoder_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_end_flag   (req_end_flag),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_end_marker (rsp_end_marker)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hex nibble of one character. Decimal digits map directly; everything else
   // is folded to lower case (letters only) and offset from 'a', so bad digits
   // wrap instead of being rejected.
   function automatic logic [7:0] nibble_of(input logic [7:0] c);
      logic [7:0] folded;
      folded = c;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         return c - CH_ZERO;
      end
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         folded = c + 8'h20;
      end
      return folded - CH_LOWER_A + HEX_TEN;
   endfunction

   function automatic void queue_decoded(input logic [7:0] b, input logic is_end);
      rsp_item_type r;
      r.out_byte   = b;
      r.end_marker = is_end;
      decoded_queue.push_back(r);
   endfunction

   // Advances the decoder model by one accepted item and queues what it yields.
   function automatic void decode_item(input logic [7:0] b, input logic is_end);
      logic [7:0] hi;
      logic [7:0] lo;
      if (is_end) begin
         // A lone '%' is dropped; with one held byte, the '%' is dropped and
         // the held byte is decoded as if no escape had started.
         if (model_phase == PHASE_HELD) begin
            if (model_held == CH_PLUS) begin
               queue_decoded(CH_SPACE, 1'b0);
            end else if (model_held != CH_PERCENT) begin
               queue_decoded(model_held, 1'b0);
            end
         end
         queue_decoded(8'h00, 1'b1);
         model_phase = PHASE_IDLE;
         model_held  = 8'h00;
      end else if (model_phase == PHASE_PCT) begin
         model_held  = b;
         model_phase = PHASE_HELD;
      end else if (model_phase == PHASE_HELD) begin
         // The low digit is ORed in whole, so a bad one reaches the high bits.
         hi = nibble_of(model_held);
         lo = nibble_of(b);
         queue_decoded({hi[3:0], 4'h0} | lo, 1'b0);
         model_phase = PHASE_IDLE;
      end else begin
         model_phase = PHASE_IDLE;
         if (b == CH_PERCENT) begin
            model_phase = PHASE_PCT;
         end else if (b == CH_PLUS) begin
            queue_decoded(CH_SPACE, 1'b0);
         end else begin
            queue_decoded(b, 1'b0);
         end
      end
   endfunction

   function automatic void push_item(input logic [7:0] b, input logic is_end);
      enc_item_type it;
      it.code   = b;
      it.is_end = is_end;
      pending_items.push_back(it);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
      if (v < 4'd10) begin
         return CH_ZERO + v;
      end
      return (upper ? CH_UPPER_A : CH_LOWER_A) + (v - 4'd10);
   endfunction

   // One random string: mostly well-formed tokens and escapes, some noise
   // bytes and broken escapes, sometimes a dangling escape before the end.
   function automatic void queue_random_string();
      int         n_tokens;
      int         pick;
      logic [7:0] c;
      n_tokens = $urandom_range(0, 10);
      for (int k = 0; k < n_tokens; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            c = 8'($urandom_range(8'h21, 8'h7E));
            if (c == CH_PERCENT) begin
               c = CH_PLUS;
            end
            push_item(c, 1'b0);
         end else if (pick < 50) begin
            push_item(CH_PLUS, 1'b0);
         end else if (pick < 80) begin
            push_item(CH_PERCENT, 1'b0);
            push_item(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))),
                      1'b0);
            push_item(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))),
                      1'b0);
         end else if (pick < 90) begin
            push_item(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            push_item(CH_PERCENT, 1'b0);
            push_item(8'($urandom_range(0, 255)), 1'b0);
            push_item(8'($urandom_range(0, 255)), 1'b0);
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         push_item(CH_PERCENT, 1'b0);
      end else if (pick < 20) begin
         push_item(CH_PERCENT, 1'b0);
         push_item(8'($urandom_range(0, 255)), 1'b0);
      end
      // The byte field of an end item is ignored, so it carries noise.
      push_item(8'($urandom_range(0, 255)), 1'b1);
   endfunction

   function automatic void report_mismatch(input rsp_item_type want);
      error_count++;
      if (error_count <= MAX_REPORTED) begin
         $display("testbench: mismatch at cycle %0d: expected byte %02h end %0b, got byte %02h end %0b",
                  cycle_count, want.out_byte, want.end_marker, rsp_out_byte, rsp_end_marker);
      end
   endfunction

   // Driver. The model is advanced at the edge where an item is accepted. A
   // new item is only taken from the queue once the current one has gone, so
   // valid and payload hold steady while the block stalls.
   always @(posedge clock) begin
      enc_item_type nxt;
      int           idle_pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_item(req_in_byte, req_end_flag);
            items_sent++;
            if (req_end_flag) begin
               ends_sent++;
            end
         end
         if (!req_valid || req_ready) begin
            case (idle_mode)
               MODE_SEND27_RECV57: idle_pct = 27;
               MODE_SEND57_RECV27: idle_pct = 57;
               default:            idle_pct = 0;
            endcase
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               nxt = pending_items.pop_front();
               req_valid    <= 1'b1;
               req_in_byte  <= nxt.code;
               req_end_flag <= nxt.is_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. It checks each accepted result item against the oldest one the
   // model queued, then decides whether the receiver is ready for the next.
   always @(posedge clock) begin
      rsp_item_type want;
      int           idle_pct;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (decoded_queue.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTED) begin
                  $display("testbench: unexpected result at cycle %0d: byte %02h end %0b",
                           cycle_count, rsp_out_byte, rsp_end_marker);
               end
            end else begin
               want = decoded_queue.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_end_marker !== want.end_marker) begin
                  report_mismatch(want);
               end
            end
         end
         // In the steady phase, with plenty still queued, the receiver stops
         // once for a long stretch so that the block backs up and stalls its
         // input while the sender keeps offering.
         if (!hold_done && idle_mode == MODE_STEADY && pending_items.size() > 40) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         case (idle_mode)
            MODE_SEND27_RECV57: idle_pct = 57;
            MODE_SEND57_RECV27: idle_pct = 27;
            default:            idle_pct = 0;
         endcase
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Waits until the sender has nothing left and every result has come back.
   task automatic wait_until_drained();
      while (pending_items.size() > 0 || req_valid || decoded_queue.size() > 0) begin
         @(posedge clock);
      end
   endtask

   task automatic run_random_phase(input idle_mode_type mode);
      int start_count;
      idle_mode   = mode;
      start_count = pending_items.size();
      while (pending_items.size() - start_count < PHASE_ITEMS) begin
         queue_random_string();
      end
      // The sender pauses here until every expected result has arrived.
      wait_until_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed cases: a zero byte passed through as data, a plus, escapes
      // with both letter cases, an escape with non-hex digits, an end while
      // idle, an end after a lone percent, ends after a percent and one held
      // byte (plus, percent, letter), and a zero byte used as a hex digit.
      idle_mode = MODE_SEND27_RECV57;
      push_item(8'h00, 1'b0);
      push_item(CH_PLUS, 1'b0);
      push_item(CH_PERCENT, 1'b0);
      push_item("4", 1'b0);
      push_item("1", 1'b0);
      push_item(CH_PERCENT, 1'b0);
      push_item("f", 1'b0);
      push_item("F", 1'b0);
      push_item(CH_PERCENT, 1'b0);
      push_item("@", 1'b0);
      push_item("[", 1'b0);
      push_item(8'hFF, 1'b1);
      push_item(CH_PERCENT, 1'b0);
      push_item(8'h00, 1'b1);
      push_item(CH_PERCENT, 1'b0);
      push_item(CH_PLUS, 1'b0);
      push_item(8'h5A, 1'b1);
      push_item(CH_PERCENT, 1'b0);
      push_item(CH_PERCENT, 1'b0);
      push_item(8'hA5, 1'b1);
      push_item(CH_PERCENT, 1'b0);
      push_item("Z", 1'b0);
      push_item(8'h00, 1'b1);
      push_item(CH_PERCENT, 1'b0);
      push_item(8'h00, 1'b0);
      push_item("9", 1'b0);
      wait_until_drained();

      run_random_phase(MODE_SEND27_RECV57);
      run_random_phase(MODE_SEND57_RECV27);
      run_random_phase(MODE_STEADY);

      // Let any stray late result items surface before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (decoded_queue.size() != 0) begin
         error_count++;
      end

      $display("testbench: %0d items sent, %0d of them string ends; %0d results checked",
               items_sent, ends_sent, results_seen);
      $display("testbench: three idle patterns and one %0d-cycle receiver stall", LONG_HOLD);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
